### design/lpd_pkg.sv
// Shared types and constants of the length-prefixed deframer.
package lpd_pkg;

   localparam int unsigned LenWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam logic [LenWidth-1:0] MaxLengthReset = 32'd1048576;
   localparam logic [LenWidth-1:0] LenOne = 32'd1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_COMMAND,
      PH_PAYLOAD,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [ByteWidth-1:0] command;
      logic [ByteWidth-1:0] data_byte;
      logic                 last;
      logic [LenWidth-1:0]  frame_length;
   } result_type;

endpackage

### design/length_prefixed_deframer_core.sv
// Top level of the length-prefixed deframer: handshake glue, parser and result register.
//
// The request channel carries one byte of a framed stream per word. Each packet is a
// four-byte big-endian length, a command byte and length minus one payload bytes.
// The response channel gives one word per payload byte, tagged with the command, the
// packet length and a last flag. A packet of length one gives a single empty-packet
// word. A length of zero or above max_length gives one error word, after which every
// further byte is taken and dropped until reset.
// The user must write max_length through csr_write_enable and csr_write_data only
// while idle; the block does not enforce this. The result word of a byte shows in the
// cycle after the byte is taken. Throughput is one byte per cycle; the only limit is
// the single result register. The block stalls a request only while a result word
// waits and the receiver stalls, so req_stall follows rsp_stall through that register
// and nothing is ever lost. Synchronous reset returns the parser to the header phase,
// sets max_length to 1048576 and empties the result register.
module length_prefixed_deframer_core import lpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [LenWidth-1:0]  csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_byte_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [ByteWidth-1:0] rsp_command,
   output logic [ByteWidth-1:0] rsp_data_byte,
   output logic                 rsp_last,
   output logic [LenWidth-1:0]  rsp_frame_length
);

   logic       word_accept;
   logic       can_load;
   logic       result_valid;
   result_type result;
   result_type out_result;

   // A request word is taken whenever the result register can absorb its result.
   assign req_stall = !can_load;
   assign word_accept = req_valid && can_load;

   lpd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .word_accept      (word_accept),
      .word_byte        (req_byte_in),
      .result_valid     (result_valid),
      .result           (result)
   );

   lpd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (word_accept),
      .load_valid  (result_valid),
      .load_result (result),
      .out_stall   (rsp_stall),
      .out_valid   (rsp_valid),
      .out_result  (out_result),
      .can_load    (can_load)
   );

   assign rsp_status = out_result.status;
   assign rsp_command = out_result.command;
   assign rsp_data_byte = out_result.data_byte;
   assign rsp_last = out_result.last;
   assign rsp_frame_length = out_result.frame_length;

   // An error word always closes the stream with zero command and data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INVALID |->
         rsp_last && rsp_command == '0 && rsp_data_byte == '0)
      else $error("error word carries command, data or no last flag");

   // An empty-packet word only comes from a length of one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_last && rsp_frame_length == LenOne)
      else $error("empty-packet word with a length other than one");

   // Payload words only come from packets with at least one payload byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DATA |-> rsp_frame_length > LenOne)
      else $error("payload word from a packet without payload");

   // Requests are held back only while a result word is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the result register free");

endmodule

### design/lpd_parser.sv
// Framing state machine: gathers the length, checks it, latches the command, counts payload.
module lpd_parser import lpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [LenWidth-1:0]  csr_write_data,
   input  logic                 word_accept,
   input  logic [ByteWidth-1:0] word_byte,
   output logic                 result_valid,
   output result_type           result
);

   phase_type            phase_ff, phase_in;
   logic [1:0]           header_count_ff, header_count_in;
   logic [LenWidth-1:0]  length_accum_ff, length_accum_in;
   logic [LenWidth-1:0]  bytes_left_ff, bytes_left_in;
   logic [ByteWidth-1:0] held_command_ff, held_command_in;
   logic [LenWidth-1:0]  max_length_ff;
   logic [LenWidth-1:0]  shifted_len;
   logic                 len_bad;

   assign shifted_len = {length_accum_ff[LenWidth-ByteWidth-1:0], word_byte};
   assign len_bad = (shifted_len == '0) || (shifted_len > max_length_ff);

   always_comb begin
      phase_in = phase_ff;
      header_count_in = header_count_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in = bytes_left_ff;
      held_command_in = held_command_ff;
      result_valid = 1'b0;
      result = '{status: ST_DATA, command: '0, data_byte: '0, last: 1'b0,
                 frame_length: length_accum_ff};
      if (word_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               length_accum_in = shifted_len;
               header_count_in = header_count_ff + 2'd1;
               if (header_count_ff == 2'd3) begin
                  if (len_bad) begin
                     phase_in = PH_DEAD;
                     result_valid = 1'b1;
                     result.status = ST_INVALID;
                     result.last = 1'b1;
                     result.frame_length = shifted_len;
                  end else begin
                     phase_in = PH_COMMAND;
                  end
               end
            end
            PH_COMMAND: begin
               held_command_in = word_byte;
               if (length_accum_ff == LenOne) begin
                  phase_in = PH_HEADER;
                  result_valid = 1'b1;
                  result.status = ST_EMPTY;
                  result.command = word_byte;
                  result.last = 1'b1;
               end else begin
                  bytes_left_in = length_accum_ff - LenOne;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               result_valid = 1'b1;
               result.status = ST_DATA;
               result.command = held_command_ff;
               result.data_byte = word_byte;
               result.last = (bytes_left_ff <= LenOne);
               if (bytes_left_ff <= LenOne) begin
                  bytes_left_in = '0;
                  phase_in = PH_HEADER;
               end else begin
                  bytes_left_in = bytes_left_ff - LenOne;
               end
            end
            PH_DEAD: begin
               phase_in = PH_DEAD;
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         header_count_ff <= '0;
         length_accum_ff <= '0;
         bytes_left_ff <= '0;
         held_command_ff <= '0;
         max_length_ff <= MaxLengthReset;
      end else begin
         phase_ff <= phase_in;
         header_count_ff <= header_count_in;
         length_accum_ff <= length_accum_in;
         bytes_left_ff <= bytes_left_in;
         held_command_ff <= held_command_in;
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
      end
   end

endmodule

### design/lpd_out_reg.sv
// Result register that holds one result word until the receiver takes it.
module lpd_out_reg import lpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       load_valid,
   input  result_type load_result,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_result,
   output logic       can_load
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // A new result may enter when the register is empty or is being emptied now.
   assign can_load = !valid_ff || !out_stall;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end
      if (load && load_valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         result_ff <= load_result;
      end
   end

   assign out_valid = valid_ff;
   assign out_result = result_ff;

endmodule
